/* rtl/dpna_pkg.sv */
package dpna_pkg;

   localparam int MAX_WIDTH_DEFAULT = 4096;
   localparam int MAX_HEIGHT        = 16384;

   localparam int PIX_W  = 16;
   localparam int WREG_W = 13;
   localparam int HREG_W = 15;
   localparam int CSR_W  = 15;
   localparam int ROW_W  = 15;
   localparam int OROW_W = 14;
   localparam int SUM_W  = 19;
   localparam int CNT_W  = 4;

   localparam logic [WREG_W-1:0] WIDTH_RESET  = WREG_W'(1024);
   localparam logic [HREG_W-1:0] HEIGHT_RESET = HREG_W'(1024);

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   // floor(x / d) == (x * ceil(2^22 / d)) >> 22 for x < 2^19, d <= 8
   localparam int RECIP_SHIFT = 22;
   localparam int RECIP_W     = 23;
   localparam int PROD_W      = SUM_W + RECIP_W;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_value;
      logic             pixel_defective;
      logic             flush_item;
   } req_payload_type;

   typedef struct packed {
      logic [PIX_W-1:0] corrected_value;
      logic             frame_last;
   } rsp_payload_type;

   function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
      logic [RECIP_W-1:0] r;
      case (cnt)
         4'd1:    r = RECIP_W'(4194304);
         4'd2:    r = RECIP_W'(2097152);
         4'd3:    r = RECIP_W'(1398102);
         4'd4:    r = RECIP_W'(1048576);
         4'd5:    r = RECIP_W'(838861);
         4'd6:    r = RECIP_W'(699051);
         4'd7:    r = RECIP_W'(599187);
         4'd8:    r = RECIP_W'(524288);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

/* rtl/defect_pixel_neighbour_average.sv */
// Defective pixel correction over a 3x3 window. Pixels arrive in raster order with a defect
// flag; a defective pixel is replaced by the truncated mean of its in-image, non-defective
// neighbours, or kept when there are none, and good pixels pass unchanged. Results lag the
// input by one line plus one pixel, so after the last pixel of a frame the caller sends
// flush items (width + 1 of them) to drain it; frame_last marks the final result. The block
// handles one item at a time: each passes through line store read, then window update and
// store write-back, and one that gives a result goes on through neighbour sum, reciprocal
// multiply and output load, waiting there while the output register is still held by the
// previous result; a flush ignored outside the drain never occupies the input. The line
// stores are single synchronous memories and start undefined; no clearing pass is run, as no
// unwritten entry ever reaches a result. Writing either size register restarts the frame.
module defect_pixel_neighbour_average #(
   parameter int MAX_WIDTH = dpna_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  dpna_pkg::req_payload_type     req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output dpna_pkg::rsp_payload_type     rsp_payload,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [dpna_pkg::CSR_W-1:0]    csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int PW    = dpna_pkg::PIX_W;
   localparam int ENT_W = PW + 1;
   localparam int ROW_W = dpna_pkg::ROW_W;

   typedef enum logic [2:0] {IDLE, WIN, SUM, MUL, OUT} state_type;

   state_type                     state_ff;
   logic [dpna_pkg::WREG_W-1:0]   width_ff;
   logic [dpna_pkg::HREG_W-1:0]   height_ff;
   logic [COL_W-1:0]              in_col_ff;
   logic [ROW_W-1:0]              in_row_ff;
   logic [COL_W-1:0]              out_col_ff;
   logic [dpna_pkg::OROW_W-1:0]   out_row_ff;
   logic                          draining_ff;
   logic [ENT_W-1:0]              cur_ff;
   logic [ENT_W-1:0]              win_ff [3][3];
   logic [dpna_pkg::SUM_W-1:0]    sum_ff;
   logic [dpna_pkg::CNT_W-1:0]    cnt_ff;
   logic [ENT_W-1:0]              centre_ff;
   logic                          last_ff;
   logic [dpna_pkg::PROD_W-1:0]   prod_ff;
   logic                          rsp_valid_ff;
   dpna_pkg::rsp_payload_type     rsp_payload_ff;

   logic [ENT_W-1:0]              upper_mem  [MAX_WIDTH];
   logic [ENT_W-1:0]              middle_mem [MAX_WIDTH];
   logic [ENT_W-1:0]              up_rd_ff;
   logic [ENT_W-1:0]              mid_rd_ff;

   logic [WID_W-1:0]              eff_w;
   logic [ROW_W-1:0]              eff_h;
   logic                          mem_we;
   logic                          emit;
   logic                          col_wrap;
   logic [ROW_W-1:0]              in_row_in;
   logic [COL_W-1:0]              in_col_in;
   logic [dpna_pkg::SUM_W-1:0]    sum_in;
   logic [dpna_pkg::CNT_W-1:0]    cnt_in;
   logic                          last_in;
   logic [PW-1:0]                 result_in;
   logic                          out_free;

   always_comb begin
      if (width_ff == '0) begin
         eff_w = WID_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_w = WID_W'(MAX_WIDTH);
      end else begin
         eff_w = WID_W'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = ROW_W'(1);
      end else if (32'(height_ff) > dpna_pkg::MAX_HEIGHT) begin
         eff_h = ROW_W'(dpna_pkg::MAX_HEIGHT);
      end else begin
         eff_h = ROW_W'(height_ff);
      end
   end

   assign mem_we = (state_ff == WIN) && !draining_ff;
   assign emit   = (in_row_ff >= ROW_W'(2)) || ((in_row_ff == ROW_W'(1)) && (in_col_ff != '0));

   always_comb begin
      col_wrap  = (WID_W'(in_col_ff) + WID_W'(1)) >= eff_w;
      in_col_in = col_wrap ? '0 : in_col_ff + COL_W'(1);
      in_row_in = col_wrap ? in_row_ff + ROW_W'(1) : in_row_ff;
   end

   always_comb begin
      logic row_ok [3];
      logic col_ok [3];
      sum_in = '0;
      cnt_in = '0;
      row_ok[0] = out_row_ff != '0;
      row_ok[1] = 1'b1;
      row_ok[2] = (ROW_W'(out_row_ff) + ROW_W'(1)) < eff_h;
      col_ok[0] = out_col_ff != '0;
      col_ok[1] = 1'b1;
      col_ok[2] = (WID_W'(out_col_ff) + WID_W'(1)) < eff_w;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (!(r == 1 && c == 1) && row_ok[r] && col_ok[c] && !win_ff[r][c][PW]) begin
               sum_in = sum_in + dpna_pkg::SUM_W'(win_ff[r][c][PW-1:0]);
               cnt_in = cnt_in + dpna_pkg::CNT_W'(1);
            end
         end
      end
      last_in = ((ROW_W'(out_row_ff) + ROW_W'(1)) >= eff_h)
             && ((WID_W'(out_col_ff) + WID_W'(1)) >= eff_w);
   end

   assign result_in = (centre_ff[PW] && cnt_ff != '0)
                    ? prod_ff[dpna_pkg::RECIP_SHIFT +: PW] : centre_ff[PW-1:0];
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      up_rd_ff  <= upper_mem[in_col_ff];
      mid_rd_ff <= middle_mem[in_col_ff];
      if (mem_we) begin
         upper_mem[in_col_ff]  <= mid_rd_ff;
         middle_mem[in_col_ff] <= cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         width_ff     <= dpna_pkg::WIDTH_RESET;
         height_ff    <= dpna_pkg::HEIGHT_RESET;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         draining_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (csr_we) begin
         case (csr_index)
            dpna_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_data[dpna_pkg::WREG_W-1:0];
            dpna_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
         state_ff     <= IDLE;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         draining_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (req_valid && !(req_payload.flush_item && !draining_ff)) begin
                  cur_ff   <= draining_ff ? '0
                            : {req_payload.pixel_defective, req_payload.pixel_value};
                  state_ff <= WIN;
               end
            end
            WIN: begin
               for (int r = 0; r < 3; r++) begin
                  win_ff[r][0] <= win_ff[r][1];
                  win_ff[r][1] <= win_ff[r][2];
               end
               win_ff[0][2] <= up_rd_ff;
               win_ff[1][2] <= mid_rd_ff;
               win_ff[2][2] <= cur_ff;
               in_col_ff    <= in_col_in;
               in_row_ff    <= in_row_in;
               if (!draining_ff && in_row_in >= eff_h) begin
                  draining_ff <= 1'b1;
               end
               state_ff <= emit ? SUM : IDLE;
            end
            SUM: begin
               sum_ff    <= sum_in;
               cnt_ff    <= cnt_in;
               centre_ff <= win_ff[1][1];
               last_ff   <= last_in;
               state_ff  <= MUL;
            end
            MUL: begin
               prod_ff  <= sum_ff * dpna_pkg::recip(cnt_ff);
               state_ff <= OUT;
            end
            OUT: begin
               if (out_free) begin
                  rsp_valid_ff                   <= 1'b1;
                  rsp_payload_ff.corrected_value <= result_in;
                  rsp_payload_ff.frame_last      <= last_ff;
                  state_ff                       <= IDLE;
                  if (last_ff) begin
                     in_col_ff   <= '0;
                     in_row_ff   <= '0;
                     out_col_ff  <= '0;
                     out_row_ff  <= '0;
                     draining_ff <= 1'b0;
                     for (int r = 0; r < 3; r++) begin
                        for (int c = 0; c < 3; c++) begin
                           win_ff[r][c] <= '0;
                        end
                     end
                  end else if ((WID_W'(out_col_ff) + WID_W'(1)) >= eff_w) begin
                     out_col_ff <= '0;
                     out_row_ff <= out_row_ff + dpna_pkg::OROW_W'(1);
                  end else begin
                     out_col_ff <= out_col_ff + COL_W'(1);
                  end
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign req_stall   = state_ff != IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

/* rtl/dpna_checker.sv */
module dpna_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input dpna_pkg::req_payload_type     req_payload,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input dpna_pkg::rsp_payload_type     rsp_payload,
   input logic                          csr_we,
   input logic                          csr_index,
   input logic [dpna_pkg::CSR_W-1:0]    csr_data
);

   // a held result stays put until transferred
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall && !csr_we |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp changed while stalled");

   // size write restarts the frame and drops any pending result
   a_csr_drop: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !rsp_valid)
      else $error("result shown after csr write");

   // a fresh result follows its input transfer through the window, sum, multiply and output states
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 5))
      else $error("result without matching input transfer");

   // input is held off just before a fresh result appears, while its item is in flight
   a_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall, 1) && $past(req_stall, 2))
      else $error("input taken while item in flight");

endmodule

bind defect_pixel_neighbour_average dpna_checker u_dpna_checker (.*);

/* sim/pixel_correction_checker.sv */
`timescale 1ns / 100ps

module pixel_correction_checker
   import dpna_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  req_payload_type     req_payload,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  rsp_payload_type     rsp_payload,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [CSR_W-1:0]    csr_data,
   output int unsigned         mismatch_count,
   output int unsigned         outstanding
);

   // bit 16 of every stored word is the defect flag
   logic [PIX_W:0]     upper_line [MAX_WIDTH];
   logic [PIX_W:0]     middle_line [MAX_WIDTH];
   logic [PIX_W:0]     window [3][3];
   logic [WREG_W-1:0]  width_reg;
   logic [HREG_W-1:0]  height_reg;
   int unsigned        in_col;
   int unsigned        in_row;
   int unsigned        out_col;
   int unsigned        out_row;
   bit                 draining;
   rsp_payload_type    expected_pixels [$];
   rsp_payload_type    want;

   function automatic int unsigned active_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
   endfunction

   function automatic int unsigned active_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
   endfunction

   task automatic restart_frame();
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            window[r][c] = '0;
         end
      end
      in_col   = 0;
      in_row   = 0;
      out_col  = 0;
      out_row  = 0;
      draining = 1'b0;
   endtask

   task automatic report_mismatch(input string what);
      if (mismatch_count < 40) begin
         $display("%0t ns: mismatch: %s", $time, what);
      end
      mismatch_count++;
   endtask

   task automatic take_item(input req_payload_type item);
      int unsigned     w;
      int unsigned     h;
      int unsigned     sum;
      int unsigned     cnt;
      int              ny;
      int              nx;
      logic [PIX_W:0]  cur;
      logic [PIX_W:0]  up;
      logic [PIX_W:0]  mid;
      bit              emit;
      rsp_payload_type res;
      w = active_width();
      h = active_height();
      if (item.flush_item && !draining) return;
      cur = draining ? '0 : {item.pixel_defective, item.pixel_value};
      up  = '0;
      mid = '0;
      if (in_col < MAX_WIDTH) begin
         up  = upper_line[in_col];
         mid = middle_line[in_col];
         if (!draining) begin
            upper_line[in_col]  = mid;
            middle_line[in_col] = cur;
         end
      end
      for (int r = 0; r < 3; r++) begin
         window[r][0] = window[r][1];
         window[r][1] = window[r][2];
      end
      window[0][2] = up;
      window[1][2] = mid;
      window[2][2] = cur;
      emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      if (!draining && in_row >= h) draining = 1'b1;
      if (!emit) return;

      res.corrected_value = window[1][1][PIX_W-1:0];
      if (window[1][1][PIX_W]) begin
         sum = 0;
         cnt = 0;
         for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
               ny = int'(out_row) + dy;
               nx = int'(out_col) + dx;
               if (dy == 0 && dx == 0) continue;
               if (ny < 0 || nx < 0 || ny >= int'(h) || nx >= int'(w)) continue;
               if (window[dy + 1][dx + 1][PIX_W]) continue;
               sum += window[dy + 1][dx + 1][PIX_W-1:0];
               cnt++;
            end
         end
         if (cnt != 0) res.corrected_value = PIX_W'(sum / cnt);
      end
      res.frame_last = 1'b0;
      if (out_row + 1 >= h && out_col + 1 >= w) begin
         res.frame_last = 1'b1;
         restart_frame();
      end else begin
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
      expected_pixels.push_back(res);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
         end
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         restart_frame();
         expected_pixels.delete();
         mismatch_count = 0;
         outstanding <= 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_IMAGE_WIDTH) begin
               width_reg = csr_data[WREG_W-1:0];
            end else begin
               height_reg = csr_data[HREG_W-1:0];
            end
            restart_frame();
         end
         if (req_valid && !req_stall) begin
            take_item(req_payload);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("result %0d / last %0b with none expected",
                                         rsp_payload.corrected_value, rsp_payload.frame_last));
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_payload.corrected_value !== want.corrected_value) begin
                  report_mismatch($sformatf("corrected_value %0d, expected %0d",
                                            rsp_payload.corrected_value, want.corrected_value));
               end
               if (rsp_payload.frame_last !== want.frame_last) begin
                  report_mismatch($sformatf("frame_last %0b, expected %0b",
                                            rsp_payload.frame_last, want.frame_last));
               end
            end
         end
         outstanding <= expected_pixels.size();
      end
   end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
   import dpna_pkg::*;

   localparam int TB_MAX_WIDTH  = MAX_WIDTH_DEFAULT;
   localparam int RANDOM_PIXELS = 400;
   localparam int SETTLE_CYCLES = 16;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   req_payload_type    req_payload = '0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   rsp_payload_type    rsp_payload;
   logic               csr_we      = 1'b0;
   logic               csr_index   = CSR_IMAGE_WIDTH;
   logic [CSR_W-1:0]   csr_data    = '0;

   int unsigned        mismatch_count;
   int unsigned        outstanding;
   int unsigned        gap_pct     = 0;
   int unsigned        stall_pct   = 0;
   int unsigned        frame_w;
   int unsigned        frame_h;
   int unsigned        pixels_sent;
   int unsigned        sel;
   int unsigned        ew;
   int unsigned        eh;
   int unsigned        frames;
   int unsigned        defect_pct;
   logic [CSR_W-1:0]   wdata;
   logic [CSR_W-1:0]   hdata;

   defect_pixel_neighbour_average #(
      .MAX_WIDTH (TB_MAX_WIDTH)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   pixel_correction_checker #(
      .MAX_WIDTH (TB_MAX_WIDTH)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(11, 1)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [PIX_W-1:0] random_value();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   task automatic choose_idling();
      case ($urandom_range(3))
         0:       gap_pct = 0;
         1:       gap_pct = 5;
         2:       gap_pct = 20;
         default: gap_pct = 50;
      endcase
      case ($urandom_range(3))
         0:       stall_pct = 0;
         1:       stall_pct = 5;
         2:       stall_pct = 20;
         default: stall_pct = 50;
      endcase
   endtask

   // one transfer; returns at the edge that takes it
   task automatic send_item(input logic [PIX_W-1:0] value, input logic defective,
                            input logic flush);
      req_payload_type item;
      if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(11, 1)) @(posedge clock);
      end
      item.pixel_value     = value;
      item.pixel_defective = defective;
      item.flush_item      = flush;
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_W-1:0] wd, input logic [CSR_W-1:0] hd,
                            input int unsigned w, input int unsigned h);
      wait_drained();
      write_reg(CSR_IMAGE_WIDTH, wd);
      write_reg(CSR_IMAGE_HEIGHT, hd);
      csr_we  <= 1'b0;
      frame_w = w;
      frame_h = h;
   endtask

   task automatic send_frame(input int unsigned pct, input bit noisy);
      for (int unsigned i = 0; i < frame_w * frame_h; i++) begin
         if (noisy && $urandom_range(99) < 3) send_item(random_value(), 1'($urandom), 1'b1);
         send_item(random_value(), $urandom_range(99) < pct, 1'b0);
         pixels_sent++;
      end
      // drain: a pixel here is dropped and counts as a flush
      for (int unsigned i = 0; i <= frame_w; i++) begin
         if (noisy && $urandom_range(99) < 15) begin
            send_item(random_value(), 1'($urandom), 1'b0);
         end else begin
            send_item(random_value(), 1'($urandom), 1'b1);
         end
      end
      if (noisy && $urandom_range(99) < 20) begin
         repeat ($urandom_range(3, 1)) send_item(random_value(), 1'($urandom), 1'b1);
      end
   endtask

   task automatic send_partial(input int unsigned n, input int unsigned pct);
      for (int unsigned i = 0; i < n; i++) begin
         send_item(random_value(), $urandom_range(99) < pct, 1'b0);
         pixels_sent++;
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset sizes, a little past the first row
      gap_pct   = 10;
      stall_pct = 10;
      frame_w   = 1024;
      frame_h   = 1024;
      send_partial(1024 + 8, 30);

      // directed
      gap_pct   = 20;
      stall_pct = 20;
      configure(CSR_W'(3), CSR_W'(3), 3, 3);
      send_item(16'hFFFF, 1'b0, 1'b0);
      send_item(16'd100,  1'b1, 1'b0);
      send_item(16'hFFFF, 1'b0, 1'b0);
      send_item(16'd7,    1'b0, 1'b0);
      send_item(16'd0,    1'b1, 1'b0);
      send_item(16'hFFFF, 1'b1, 1'b0);
      send_item(16'd1,    1'b0, 1'b0);
      send_item(16'hFFFF, 1'b1, 1'b0);
      send_item(16'd0,    1'b0, 1'b0);
      send_item(16'd0,    1'b0, 1'b1);
      send_item(16'd12345, 1'b1, 1'b0);
      send_item(16'd0,    1'b0, 1'b1);
      send_item(16'd0,    1'b0, 1'b1);
      send_item(16'hFFFF, 1'b1, 1'b1);
      // zero sizes act as one
      configure('0, '0, 1, 1);
      send_item(16'd500, 1'b1, 1'b0);
      send_item(16'd0,   1'b0, 1'b1);
      send_item(16'd0,   1'b0, 1'b1);
      // all defective: every pixel keeps its value
      configure(CSR_W'(2), CSR_W'(2), 2, 2);
      send_item(16'd3,    1'b1, 1'b1);
      send_item(16'd9,    1'b1, 1'b0);
      send_item(16'd8,    1'b1, 1'b0);
      send_item(16'd4,    1'b0, 1'b1);
      send_item(16'd7,    1'b1, 1'b0);
      send_item(16'hFFFF, 1'b1, 1'b0);
      repeat (3) send_item(16'd0, 1'b0, 1'b1);

      pixels_sent = 0;
      while (pixels_sent < RANDOM_PIXELS) begin
         choose_idling();
         sel = $urandom_range(99);
         if (sel < 65) begin
            ew = $urandom_range(8, 1);
            eh = $urandom_range(6, 1);
         end else if (sel < 80) begin
            ew = $urandom_range(40, 9);
            eh = $urandom_range(3, 1);
         end else begin
            ew = $urandom_range(4, 1);
            eh = $urandom_range(12, 7);
         end
         wdata = CSR_W'(ew);
         hdata = CSR_W'(eh);
         if ($urandom_range(9) == 0) begin
            wdata = wdata | (CSR_W'($urandom_range(3, 1)) << WREG_W);
         end
         if ($urandom_range(9) == 0) begin
            wdata[WREG_W-1:0] = '0;
            ew = 1;
         end
         if ($urandom_range(9) == 0) begin
            hdata = '0;
            eh = 1;
         end
         configure(wdata, hdata, ew, eh);
         frames = $urandom_range(3, 1);
         for (int unsigned f = 0; f < frames; f++) begin
            case ($urandom_range(3))
               0:       defect_pct = 5;
               1:       defect_pct = 30;
               2:       defect_pct = 60;
               default: defect_pct = 95;
            endcase
            if (f + 1 == frames && $urandom_range(9) == 0) begin
               send_partial($urandom_range(frame_w * frame_h, 1), defect_pct);
            end else begin
               send_frame(defect_pct, 1'b1);
            end
         end
      end

      // largest sizes, saturated register values among them
      gap_pct   = 5;
      stall_pct = 5;
      configure(CSR_W'(13'h1FFF), '0, TB_MAX_WIDTH, 1);
      send_partial(16, 30);
      configure(CSR_W'(1), CSR_W'(15'h7FFF), 1, MAX_HEIGHT);
      send_partial(48, 50);

      // no idling to finish
      gap_pct   = 0;
      stall_pct = 0;
      repeat (3) begin
         ew = $urandom_range(8, 1);
         eh = $urandom_range(6, 1);
         configure(CSR_W'(ew), CSR_W'(eh), ew, eh);
         send_frame(30, 1'b0);
      end
      wait_drained();
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/dpna_pkg.sv
rtl/defect_pixel_neighbour_average.sv
rtl/dpna_checker.sv
sim/pixel_correction_checker.sv
sim/tb.sv
